### sv/ir_pdd_pkg.sv
package ir_pdd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned TolW   = 20;
  localparam int unsigned CountW = 6;
  localparam int unsigned MotionW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Key codes of the remote
  localparam logic [TimeW-1:0] KeyUp    = 32'd551486205;
  localparam logic [TimeW-1:0] KeyLeft  = 32'd551542815;
  localparam logic [TimeW-1:0] KeyDown  = 32'd551518845;
  localparam logic [TimeW-1:0] KeyRight = 32'd551510175;
  localparam logic [TimeW-1:0] KeyOk    = 32'd551494365;
  localparam logic [TimeW-1:0] KeyPower = 32'd551489775;

  // Register reset values
  localparam logic [TimeW-1:0]  LeaderMinRst  = 32'd520000;
  localparam logic [TimeW-1:0]  LeaderMaxRst  = 32'd560000;
  localparam logic [TimeW-1:0]  ZeroTimeRst   = 32'd45000;
  localparam logic [TimeW-1:0]  OneTimeRst    = 32'd90000;
  localparam logic [TolW-1:0]   BitTolRst     = 20'd5000;
  localparam logic [TimeW-1:0]  FrameTotalRst = 32'd2800000;
  localparam logic [CountW-1:0] EdgesRst      = 6'd33;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEADER_MIN  = 3'd0,
    CFG_LEADER_MAX  = 3'd1,
    CFG_ZERO_TIME   = 3'd2,
    CFG_ONE_TIME    = 3'd3,
    CFG_BIT_TOL     = 3'd4,
    CFG_FRAME_TOTAL = 3'd5,
    CFG_EDGES       = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_LEADER = 4'b0010,
    PH_BITS   = 4'b0100,
    PH_ACTION = 4'b1000
  } phase_e;

  typedef enum logic [MotionW-1:0] {
    MOT_NONE    = 3'd0,
    MOT_STOP    = 3'd1,
    MOT_FORWARD = 3'd2,
    MOT_REVERSE = 3'd3,
    MOT_CCW     = 3'd4,
    MOT_CW      = 3'd5
  } motion_e;

  typedef struct packed {
    logic [MotionW-1:0] motion;
    logic               auto_on;
    logic               led_off;
    logic               frame_done;
    logic [TimeW-1:0]   frame_code;
  } cmd_t;

endpackage

### sv/ir_pdd_edge_if.sv
interface ir_pdd_edge_if import ir_pdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

### sv/ir_pdd_cmd_if.sv
interface ir_pdd_cmd_if import ir_pdd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MotionW-1:0] motion;
  logic               auto_on;
  logic               led_off;
  logic               frame_done;
  logic [TimeW-1:0]   frame_code;

  modport source (output valid, output motion, output auto_on, output led_off,
                  output frame_done, output frame_code, input ready);
  modport sink   (input valid, input motion, input auto_on, input led_off,
                  input frame_done, input frame_code, output ready);
endinterface

### sv/ir_pdd_cfg_if.sv
interface ir_pdd_cfg_if import ir_pdd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/ir_pulse_distance_decoder.sv
// Pulse-distance IR remote decoder.
// edge_i carries one item per falling edge of the IR receiver: the value of a
// free-running tick counter at that edge. cmd_o returns exactly one item per
// edge item: motion command, auto mode flag, LED-off request, and on the edge
// after a frame ends, frame_done with the decoded 32-bit code.
// cfg_i writes the timing registers (index 0..6); it is always ready and is
// only to be used while no edge item is in flight.
// An accepted item passes through the input register, then the result
// register, to cmd_o. Throughput: one item per cycle while cmd_o does not
// stall; the whole decode of an edge is one pass of compare, shift and add
// logic between the two registers.
// When cmd_o stalls, the result register holds its item and the input register
// takes one more; edge_i.ready then drops until the result is taken.
// Reset (rst_ni low) returns to idle, clears the frame state and auto mode and
// loads the default timing registers.
module ir_pulse_distance_decoder import ir_pdd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ir_pdd_edge_if.sink      edge_i,
  ir_pdd_cfg_if.sink       cfg_i,
  ir_pdd_cmd_if.source     cmd_o
);

  // Timing registers
  logic [TimeW-1:0]  leader_min_q, leader_max_q, zero_time_q, one_time_q, frame_total_q;
  logic [TolW-1:0]   bit_tol_q;
  logic [CountW-1:0] edges_q;

  // Bit windows, recomputed from the registers every cycle
  logic [TimeW-1:0] zero_lo_q, one_lo_q;
  logic [TimeW:0]   zero_hi_q, one_hi_q;

  // Frame state
  phase_e            phase_q, phase_d;
  logic [TimeW-1:0]  ref_q, ref_d;
  logic [TimeW-1:0]  code_q, code_d;
  logic [TimeW-1:0]  sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d;
  logic              auto_q, auto_d;

  // Pipeline registers
  logic             in_valid_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_valid_q;
  cmd_t             out_q, res;

  logic             advance;
  logic [TimeW-1:0] diff;
  logic             zero_hit, one_hit;
  logic [TimeW-1:0] sum_inc;

  assign cfg_i.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_min_q  <= LeaderMinRst;
      leader_max_q  <= LeaderMaxRst;
      zero_time_q   <= ZeroTimeRst;
      one_time_q    <= OneTimeRst;
      bit_tol_q     <= BitTolRst;
      frame_total_q <= FrameTotalRst;
      edges_q       <= EdgesRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_LEADER_MIN:  leader_min_q  <= cfg_i.data;
        CFG_LEADER_MAX:  leader_max_q  <= cfg_i.data;
        CFG_ZERO_TIME:   zero_time_q   <= cfg_i.data;
        CFG_ONE_TIME:    one_time_q    <= cfg_i.data;
        CFG_BIT_TOL:     bit_tol_q     <= cfg_i.data[TolW-1:0];
        CFG_FRAME_TOTAL: frame_total_q <= cfg_i.data;
        CFG_EDGES:       edges_q       <= cfg_i.data[CountW-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Window bounds: lower saturates at zero, upper keeps its carry bit.
  // A write settles here in the next cycle, before any item can reach the decode.
  always_ff @(posedge clk_i) begin
    zero_lo_q <= (zero_time_q >= TimeW'(bit_tol_q)) ? zero_time_q - TimeW'(bit_tol_q) : '0;
    one_lo_q  <= (one_time_q >= TimeW'(bit_tol_q)) ? one_time_q - TimeW'(bit_tol_q) : '0;
    zero_hi_q <= {1'b0, zero_time_q} + (TimeW+1)'(bit_tol_q);
    one_hi_q  <= {1'b0, one_time_q} + (TimeW+1)'(bit_tol_q);
  end

  // Advance the held item when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || cmd_o.ready);
  assign edge_i.ready = !in_valid_q || advance;

  assign diff     = in_time_q - ref_q;
  assign zero_hit = (diff >= zero_lo_q) && ({1'b0, diff} <= zero_hi_q);
  assign one_hit  = (diff >= one_lo_q) && ({1'b0, diff} <= one_hi_q);
  // Both windows matching adds the interval twice
  assign sum_inc  = (zero_hit && one_hit) ? {diff[TimeW-2:0], 1'b0} : diff;

  always_comb begin
    phase_d = phase_q;
    ref_d   = ref_q;
    code_d  = code_q;
    sum_d   = sum_q;
    count_d = count_q;
    auto_d  = auto_q;
    res     = '0;

    unique case (phase_q)
      PH_IDLE: begin
        ref_d   = in_time_q;
        phase_d = PH_LEADER;
      end
      PH_LEADER: begin
        if (diff >= leader_min_q && diff <= leader_max_q) begin
          ref_d   = in_time_q;
          phase_d = PH_BITS;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_BITS: begin
        priority if (zero_hit && one_hit) begin
          code_d = {code_q[TimeW-3:0], 2'b01};
        end else if (one_hit) begin
          code_d = {code_q[TimeW-2:0], 1'b1};
        end else if (zero_hit) begin
          code_d = {code_q[TimeW-2:0], 1'b0};
        end else begin
          // no window matched: hold the code
        end
        if (zero_hit || one_hit) begin
          sum_d = sum_q + sum_inc;
          ref_d = in_time_q;
        end
        count_d = count_q + CountW'(1);
        if (count_d >= edges_q || sum_d == frame_total_q) phase_d = PH_ACTION;
      end
      PH_ACTION: begin
        res.frame_done = 1'b1;
        res.frame_code = code_q;
        priority if (code_q == KeyOk) begin
          res.motion = MOT_STOP;
          auto_d     = 1'b0;
        end else if (code_q == KeyUp) begin
          res.motion  = MOT_FORWARD;
          auto_d      = 1'b0;
          res.led_off = 1'b1;
        end else if (code_q == KeyDown) begin
          res.motion  = MOT_REVERSE;
          auto_d      = 1'b0;
          res.led_off = 1'b1;
        end else if (code_q == KeyLeft) begin
          res.motion  = MOT_CCW;
          auto_d      = 1'b0;
          res.led_off = 1'b1;
        end else if (code_q == KeyRight) begin
          res.motion  = MOT_CW;
          auto_d      = 1'b0;
          res.led_off = 1'b1;
        end else if (code_q == KeyPower) begin
          res.motion  = MOT_STOP;
          auto_d      = !auto_q;
          res.led_off = auto_q;
        end else begin
          // unknown code: no command, keep auto mode
        end
        // Drop the frame and return to idle
        phase_d = PH_IDLE;
        ref_d   = '0;
        code_d  = '0;
        sum_d   = '0;
        count_d = '0;
      end
      default: phase_d = PH_IDLE;
    endcase
    res.auto_on = auto_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ref_q   <= '0;
      code_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
      auto_q  <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      ref_q   <= ref_d;
      code_q  <= code_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      auto_q  <= auto_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (edge_i.valid && edge_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_i.valid && edge_i.ready) in_time_q <= edge_i.edge_time;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign cmd_o.valid      = out_valid_q;
  assign cmd_o.motion     = out_q.motion;
  assign cmd_o.auto_on    = out_q.auto_on;
  assign cmd_o.led_off    = out_q.led_off;
  assign cmd_o.frame_done = out_q.frame_done;
  assign cmd_o.frame_code = out_q.frame_code;

  // The action always ends in idle
  a_action_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == PH_ACTION) |=> (phase_q == PH_IDLE))
    else $error("action edge did not return to idle");

  // Outside a finished frame the command fields stay quiet
  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.valid && !cmd_o.frame_done) |->
      (cmd_o.frame_code == '0 && cmd_o.motion == MOT_NONE && !cmd_o.led_off))
    else $error("command reported without a finished frame");

  // Idle carries no frame state
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (code_q == '0 && sum_q == '0 && count_q == '0))
    else $error("frame state left over in idle");

endmodule

### test/ir_pulse_distance_decoder_tb.sv
`timescale 1ns / 100ps

module ir_pulse_distance_decoder_tb;
  import ir_pdd_pkg::*;

  // Timing registers as the decoder holds them (already masked to width)
  typedef struct packed {
    logic [TimeW-1:0]  leader_min;
    logic [TimeW-1:0]  leader_max;
    logic [TimeW-1:0]  zero_time;
    logic [TimeW-1:0]  one_time;
    logic [TolW-1:0]   tol;
    logic [TimeW-1:0]  frame_total;
    logic [CountW-1:0] edges;
  } timing_cfg_t;

  // Frame state of the decoder
  typedef struct packed {
    phase_e            phase;
    logic [TimeW-1:0]  ref_time;
    logic [TimeW-1:0]  code;
    logic [TimeW-1:0]  sum;
    logic [CountW-1:0] count;
    logic              auto_on;
  } decoder_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ir_pdd_edge_if edge_bus ();
  ir_pdd_cfg_if  cfg_bus ();
  ir_pdd_cmd_if  cmd_bus ();

  // Testbench-side drive of every block input, known from time zero
  logic             edge_valid  = 1'b0;
  logic [TimeW-1:0] edge_time_q = '0;
  logic             cmd_ready   = 1'b1;
  logic             cfg_valid   = 1'b0;
  cfg_idx_e         cfg_index   = CFG_LEADER_MIN;
  logic [CfgDataW-1:0] cfg_data = '0;

  assign edge_bus.valid     = edge_valid;
  assign edge_bus.edge_time = edge_time_q;
  assign cmd_bus.ready      = cmd_ready;
  assign cfg_bus.valid      = cfg_valid;
  assign cfg_bus.index      = cfg_index;
  assign cfg_bus.data       = cfg_data;

  ir_pulse_distance_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .edge_i (edge_bus),
    .cfg_i  (cfg_bus),
    .cmd_o  (cmd_bus)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state, advanced at each accepted item
  timing_cfg_t    cfg_model;
  decoder_state_t dec_model;
  cmd_t           awaited_cmds[$];

  // Stimulus planning: its own copy of the state, run ahead of the block
  decoder_state_t gen_state;
  logic [TimeW-1:0] target_code;
  int unsigned      frame_bit;
  logic [TimeW-1:0] edge_backlog[$];

  int unsigned items_pushed   = 0;
  int unsigned edges_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned cfg_writes     = 0;
  int unsigned fail_count     = 0;

  logic edge_taken = 1'b0;
  logic calm       = 1'b0;
  logic hold_off   = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  function automatic timing_cfg_t timing_defaults();
    timing_cfg_t c;
    c.leader_min  = LeaderMinRst;
    c.leader_max  = LeaderMaxRst;
    c.zero_time   = ZeroTimeRst;
    c.one_time    = OneTimeRst;
    c.tol         = BitTolRst;
    c.frame_total = FrameTotalRst;
    c.edges       = EdgesRst;
    return c;
  endfunction

  function automatic timing_cfg_t timing(logic [31:0] lmin, logic [31:0] lmax,
                                         logic [31:0] zero, logic [31:0] one,
                                         logic [19:0] tol, logic [31:0] total,
                                         logic [5:0] edges);
    timing_cfg_t c;
    c.leader_min  = lmin;
    c.leader_max  = lmax;
    c.zero_time   = zero;
    c.one_time    = one;
    c.tol         = tol;
    c.frame_total = total;
    c.edges       = edges;
    return c;
  endfunction

  function automatic decoder_state_t cleared_frame(logic auto_on);
    decoder_state_t s;
    s.phase    = PH_IDLE;
    s.ref_time = '0;
    s.code     = '0;
    s.sum      = '0;
    s.count    = '0;
    s.auto_on  = auto_on;
    return s;
  endfunction

  // Window [nominal - tol, nominal + tol]: floor saturates at 0, top has no wrap
  function automatic logic bit_match(logic [TimeW-1:0] diff, logic [TimeW-1:0] nominal,
                                     logic [TolW-1:0] tol);
    logic [TimeW:0] lo;
    logic [TimeW:0] hi;
    lo = (nominal >= TimeW'(tol)) ? {1'b0, nominal} - (TimeW+1)'(tol) : '0;
    hi = {1'b0, nominal} + (TimeW+1)'(tol);
    return ({1'b0, diff} >= lo) && ({1'b0, diff} <= hi);
  endfunction

  // Work out the command item that one edge causes, and advance the state
  function automatic cmd_t decode_edge(inout decoder_state_t s, input timing_cfg_t c,
                                       input logic [TimeW-1:0] t);
    logic [TimeW-1:0] diff;
    cmd_t r;
    diff = t - s.ref_time;
    r = '0;
    case (s.phase)
      PH_IDLE: begin
        s.ref_time = t;
        s.phase    = PH_LEADER;
      end
      PH_LEADER: begin
        if (diff >= c.leader_min && diff <= c.leader_max) begin
          s.ref_time = t;
          s.phase    = PH_BITS;
        end else begin
          s.phase = PH_IDLE;
        end
      end
      PH_BITS: begin
        // Overlapping windows shift a 0 then a 1 and add the interval twice
        if (bit_match(diff, c.zero_time, c.tol)) begin
          s.code     = {s.code[TimeW-2:0], 1'b0};
          s.sum      = s.sum + diff;
          s.ref_time = t;
        end
        if (bit_match(diff, c.one_time, c.tol)) begin
          s.code     = {s.code[TimeW-2:0], 1'b1};
          s.sum      = s.sum + diff;
          s.ref_time = t;
        end
        s.count = s.count + CountW'(1);
        if (s.count >= c.edges || s.sum == c.frame_total) s.phase = PH_ACTION;
      end
      default: begin
        // The edge time itself plays no part here
        r.frame_code = s.code;
        r.frame_done = 1'b1;
        case (s.code)
          KeyOk: begin
            r.motion  = MOT_STOP;
            s.auto_on = 1'b0;
          end
          KeyUp: begin
            r.motion  = MOT_FORWARD;
            s.auto_on = 1'b0;
            r.led_off = 1'b1;
          end
          KeyDown: begin
            r.motion  = MOT_REVERSE;
            s.auto_on = 1'b0;
            r.led_off = 1'b1;
          end
          KeyLeft: begin
            r.motion  = MOT_CCW;
            s.auto_on = 1'b0;
            r.led_off = 1'b1;
          end
          KeyRight: begin
            r.motion  = MOT_CW;
            s.auto_on = 1'b0;
            r.led_off = 1'b1;
          end
          KeyPower: begin
            r.motion = MOT_STOP;
            if (!s.auto_on) begin
              s.auto_on = 1'b1;
            end else begin
              s.auto_on = 1'b0;
              r.led_off = 1'b1;
            end
          end
          default: ;
        endcase
        s = cleared_frame(s.auto_on);
      end
    endcase
    r.auto_on = s.auto_on;
    return r;
  endfunction

  // Mostly key codes, with the power key favoured so that it toggles both ways
  function automatic logic [TimeW-1:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1, 2: return KeyPower;
      3:       return KeyOk;
      4:       return KeyUp;
      5:       return KeyDown;
      6:       return KeyLeft;
      7:       return KeyRight;
      default: return $urandom;
    endcase
  endfunction

  // Interval inside a window, now and then right on one of its bounds
  function automatic logic [TimeW-1:0] pick_in_window(logic [TimeW-1:0] nominal,
                                                      logic [TolW-1:0] tol);
    logic [TimeW:0]   hi_wide;
    logic [TimeW-1:0] lo;
    logic [TimeW-1:0] hi;
    lo      = (nominal >= TimeW'(tol)) ? nominal - TimeW'(tol) : '0;
    hi_wide = {1'b0, nominal} + (TimeW+1)'(tol);
    hi      = hi_wide[TimeW] ? '1 : hi_wide[TimeW-1:0];
    case ($urandom_range(0, 9))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Interval that matches neither bit window, where one can be found
  function automatic logic [TimeW-1:0] pick_off_window();
    logic [TimeW-1:0] d;
    d = cfg_model.one_time + TimeW'(cfg_model.tol) + 1 + $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      if (bit_match(d, cfg_model.zero_time, cfg_model.tol) ||
          bit_match(d, cfg_model.one_time, cfg_model.tol)) d = $urandom;
    end
    return d;
  endfunction

  // Choose the next edge time so that most frames run to the end
  function automatic logic [TimeW-1:0] plan_edge();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (gen_state.phase)
      PH_IDLE: begin
        if (roll < 20) return 32'hFFFF_FFFF - $urandom_range(0, 3000000);
        if (roll < 22) return '0;
        return $urandom;
      end
      PH_LEADER: begin
        if (roll < 80)
          return gen_state.ref_time + $urandom_range(cfg_model.leader_max,
                                                     cfg_model.leader_min);
        if (roll < 85) return gen_state.ref_time + cfg_model.leader_min;
        if (roll < 90) return gen_state.ref_time + cfg_model.leader_max;
        if (roll < 95) return gen_state.ref_time + cfg_model.leader_max + 1;
        return $urandom;
      end
      PH_BITS: begin
        if (roll < 5) return $urandom;
        if (roll < 9 || frame_bit >= TimeW) return gen_state.ref_time + pick_off_window();
        frame_bit++;
        if (target_code[TimeW-frame_bit])
          return gen_state.ref_time + pick_in_window(cfg_model.one_time, cfg_model.tol);
        return gen_state.ref_time + pick_in_window(cfg_model.zero_time, cfg_model.tol);
      end
      default: return $urandom;
    endcase
  endfunction

  // Queue an edge item for the driver and follow it in the planning state
  function automatic void queue_edge(logic [TimeW-1:0] t);
    phase_e was;
    was = gen_state.phase;
    void'(decode_edge(gen_state, cfg_model, t));
    if (was == PH_LEADER && gen_state.phase == PH_BITS) begin
      target_code = pick_code();
      frame_bit   = 0;
    end
    edge_backlog.push_back(t);
    items_pushed++;
  endfunction

  task automatic queue_frames(int unsigned n);
    repeat (n) queue_edge(plan_edge());
  endtask

  // Call at a falling edge; returns at the falling edge after the write is taken
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    int unsigned start;
    start = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk_i); while (cfg_writes == start);
  endtask

  // Write every register; junk above the register width must be dropped
  task automatic apply_timing(timing_cfg_t c);
    write_reg(CFG_LEADER_MIN, c.leader_min);
    write_reg(CFG_LEADER_MAX, c.leader_max);
    write_reg(CFG_ZERO_TIME, c.zero_time);
    write_reg(CFG_ONE_TIME, c.one_time);
    write_reg(CFG_BIT_TOL, {12'($urandom), c.tol});
    write_reg(CFG_FRAME_TOTAL, c.frame_total);
    write_reg(CFG_EDGES, {26'($urandom), c.edges});
    cfg_valid <= 1'b0;
  endtask

  // Wait for every awaited command item, then let the pipeline drain
  task automatic settle();
    do @(negedge clk_i); while (results_seen != items_pushed);
    repeat (4) @(negedge clk_i);
  endtask

  // Edge driver: hold an offered item until taken, idle in random bursts
  always @(negedge clk_i) begin : edge_driver
    logic             nxt_valid;
    logic [TimeW-1:0] nxt_time;
    nxt_valid = edge_valid;
    nxt_time  = edge_time_q;
    if (edge_valid && !edge_taken) begin
      // hold the item
    end else if (send_gap != 0) begin
      send_gap--;
      nxt_valid = 1'b0;
    end else if (edge_backlog.size() == 0) begin
      nxt_valid = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      send_gap  = $urandom_range(1, 8) - 1;
      nxt_valid = 1'b0;
    end else begin
      nxt_time  = edge_backlog.pop_front();
      nxt_valid = 1'b1;
    end
    edge_valid  <= nxt_valid;
    edge_time_q <= nxt_time;
  end

  // Command receiver: random stall bursts, and the long hold-off when asked
  always @(negedge clk_i) begin : cmd_receiver
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (hold_off) begin
      nxt_ready = 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      nxt_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      recv_gap  = $urandom_range(1, 8) - 1;
      nxt_ready = 1'b0;
    end
    cmd_ready <= nxt_ready;
  end

  // Hold the receiver off for a long stretch while edges keep coming, so
  // that both registers fill and the block drops edge ready
  initial begin : long_stall
    wait (edges_accepted >= 100);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Sample handshakes at the rising edge: check results, predict, track writes
  always @(posedge clk_i) begin : scoreboard
    cmd_t got;
    cmd_t want;
    edge_taken = rst_ni && edge_valid && edge_bus.ready;
    if (rst_ni && cmd_bus.valid && cmd_ready) begin
      got.motion     = cmd_bus.motion;
      got.auto_on    = cmd_bus.auto_on;
      got.led_off    = cmd_bus.led_off;
      got.frame_done = cmd_bus.frame_done;
      got.frame_code = cmd_bus.frame_code;
      results_seen++;
      if (awaited_cmds.size() == 0) begin
        $error("command item with none awaited: %p", got);
        fail_count++;
      end else begin
        want = awaited_cmds.pop_front();
        if (got.motion !== want.motion) begin
          $error("motion: expected %0d, got %0d", want.motion, got.motion);
          fail_count++;
        end
        if (got.auto_on !== want.auto_on) begin
          $error("auto_on: expected %0b, got %0b", want.auto_on, got.auto_on);
          fail_count++;
        end
        if (got.led_off !== want.led_off) begin
          $error("led_off: expected %0b, got %0b", want.led_off, got.led_off);
          fail_count++;
        end
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
          fail_count++;
        end
        if (got.frame_code !== want.frame_code) begin
          $error("frame_code: expected %h, got %h", want.frame_code, got.frame_code);
          fail_count++;
        end
      end
    end
    if (edge_taken) begin
      awaited_cmds.push_back(decode_edge(dec_model, cfg_model, edge_time_q));
      edges_accepted++;
    end
    if (rst_ni && cfg_valid && cfg_bus.ready) begin
      case (cfg_index)
        CFG_LEADER_MIN:  cfg_model.leader_min  = cfg_data;
        CFG_LEADER_MAX:  cfg_model.leader_max  = cfg_data;
        CFG_ZERO_TIME:   cfg_model.zero_time   = cfg_data;
        CFG_ONE_TIME:    cfg_model.one_time    = cfg_data;
        CFG_BIT_TOL:     cfg_model.tol         = cfg_data[TolW-1:0];
        CFG_FRAME_TOTAL: cfg_model.frame_total = cfg_data;
        CFG_EDGES:       cfg_model.edges       = cfg_data[CountW-1:0];
        default: ;
      endcase
      cfg_writes++;
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("ir_pulse_distance_decoder_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    cfg_model = timing_defaults();
    dec_model = cleared_frame(1'b0);
    gen_state = cleared_frame(1'b0);
    target_code = '0;
    frame_bit   = 0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset timing: leader bounds, wrap, bit bounds
    queue_edge(32'hFFFF_FFFF);   // all ones: sets the reference
    queue_edge(32'd519998);      // wraps: one tick short of the leader floor
    queue_edge(32'd0);           // all zeros: new reference
    queue_edge(32'd560001);      // one tick over the leader ceiling
    queue_edge(32'd100);
    queue_edge(32'd560100);      // leader exactly at the ceiling
    queue_edge(32'd600100);      // zero bit on its lower bound
    queue_edge(32'd695100);      // one bit on its upper bound
    queue_edge(32'd735099);      // just under the zero window: reference stays
    queue_edge(32'd745101);      // just over the zero window
    queue_edge(32'd745100);      // zero bit on its upper bound
    queue_edge(32'd830100);      // one bit on its lower bound
    queue_edge(32'd915099);      // just under the one window
    queue_edge(32'd925101);      // just over the one window
    queue_frames(200);
    settle();

    // Tiny ticks: the running total often lands on the frame total exactly
    apply_timing(timing(32'd100, 32'd200, 32'd3, 32'd7, 20'd1, 32'd160, 6'd33));
    queue_frames(200);
    settle();

    // Widest settings: any leader, full tolerance, the sum wraps
    apply_timing(timing(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 20'hF_FFFF,
                        32'hFFFF_FFFF, 6'd63));
    queue_frames(200);
    settle();

    // Identical bit windows, and zero edges per frame
    apply_timing(timing(32'd500, 32'd500, 32'd1000, 32'd1000, 20'd10, 32'd123456,
                        6'd0));
    queue_frames(150);
    settle();

    // Empty leader window: no frame can start
    apply_timing(timing(32'd10, 32'd5, 32'd45000, 32'd90000, 20'd0, 32'd2800000,
                        6'd1));
    queue_frames(60);
    settle();

    // Zero-length leader and zero bits, frame total of zero
    apply_timing(timing(32'd0, 32'd0, 32'd0, 32'd1, 20'd0, 32'd0, 6'd40));
    queue_frames(150);
    settle();

    // Last part: back to the reset timing, no idling on either side
    calm = 1'b1;
    apply_timing(timing_defaults());
    queue_frames(300);
    settle();

    if (awaited_cmds.size() != 0) begin
      $error("%0d command items never arrived", awaited_cmds.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ir_pulse_distance_decoder_tb: PASS");
    end else begin
      $display("ir_pulse_distance_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
